/* rtl/core/snz_pkg.sv */
// ----------------------------------------------------------------------------
// snz_pkg: shared constants, types and functions for the simplex noise block
// Holds the fixed-point constants, the hash generator step and gradient dots.
// ----------------------------------------------------------------------------
package snz_pkg;

  localparam int unsigned AddrW    = 8;
  localparam int unsigned TableDep = 256;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned OutW     = 16;
  localparam int unsigned Corners  = 4;

  // generator state after reset
  localparam logic [31:0] SeedReset = 32'd1;

  // ceil(2^25 / 3): floor divide by three of the cell numerator
  localparam logic [24:0] RecipCell = 25'd11184811;
  // bias 3 * 2^19 keeps the cell numerator non-negative
  localparam logic [21:0] CellBias  = 22'd1572864;
  localparam logic [19:0] CellShift = 20'd524288;

  // ceil(2^32 / 3): floor divide by three of the offset numerator
  localparam logic [31:0] RecipOff = 32'd1431655766;
  // bias 3 * 2^28 for the offset numerator
  localparam logic [29:0] OffBias  = 30'd805306368;
  localparam logic [28:0] OffShift = 29'd268435456;

  // corner offsets in q24 relative to the first corner, split into quotient
  // and remainder of (k - 6a) * 2^23 by three
  localparam logic signed [28:0] C1Near = 29'sd2796202;
  localparam logic signed [28:0] C1Far  = -29'sd13981014;
  localparam logic signed [28:0] C2Near = 29'sd5592405;
  localparam logic signed [28:0] C2Far  = -29'sd11184811;
  localparam logic signed [28:0] C3Off  = -29'sd8388608;

  // round(0.6 * 2^48)
  localparam logic signed [53:0] RadiusSq = 54'sd168884986026394;
  localparam logic [48:0] HalfQ24 = 49'd8388608;

  typedef logic signed [26:0] coord_t;

  // tetrahedron step flags
  typedef struct packed {
    logic i1;
    logic j1;
    logic k1;
    logic i2;
    logic j2;
    logic k2;
  } tetra_t;

  // one xorshift32 step
  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // byte mod 12: (b / 4 mod 3) * 4 + b mod 4
  function automatic logic [3:0] mod12(input logic [7:0] b);
    logic [5:0]  v;
    logic [12:0] p;
    logic [5:0]  q;
    logic [5:0]  r;
    v = b[7:2];
    p = 13'(v) * 13'd43;
    q = p[12:7];
    r = v - 6'(q << 1) - q;
    return {r[1:0], b[1:0]};
  endfunction

  // dot product with the edge gradient selected by codes 0 to 11
  function automatic logic signed [27:0] grad_dot(input logic [3:0] g, input coord_t x,
                                                  input coord_t y, input coord_t z);
    logic signed [27:0] xe;
    logic signed [27:0] ye;
    logic signed [27:0] ze;
    logic signed [27:0] r;
    xe = {x[26], x};
    ye = {y[26], y};
    ze = {z[26], z};
    unique case (g)
      4'd0:    r = xe + ye;
      4'd1:    r = ye - xe;
      4'd2:    r = xe - ye;
      4'd3:    r = -xe - ye;
      4'd4:    r = xe + ze;
      4'd5:    r = ze - xe;
      4'd6:    r = xe - ze;
      4'd7:    r = -xe - ze;
      4'd8:    r = ye + ze;
      4'd9:    r = ze - ye;
      4'd10:   r = ye - ze;
      4'd11:   r = -ye - ze;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/snz_tables.sv */
// ----------------------------------------------------------------------------
// snz_tables: hash and gradient index tables with their builder
// Rebuilds the tables from the seed, one entry a cycle, and serves three
// dependent lookup levels for four corners with registered read data.
// ----------------------------------------------------------------------------
module snz_tables (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [31:0]                              cfg_wdata_i,
  input  logic                                     rd_en_i,
  input  logic [snz_pkg::Corners-1:0][snz_pkg::AddrW-1:0] addr1_i,
  input  logic [snz_pkg::Corners-1:0][snz_pkg::AddrW-1:0] addr2_i,
  input  logic [snz_pkg::Corners-1:0][snz_pkg::AddrW-1:0] addr3_i,
  output logic [snz_pkg::Corners-1:0][snz_pkg::AddrW-1:0] h1_o,
  output logic [snz_pkg::Corners-1:0][snz_pkg::AddrW-1:0] h2_o,
  output logic [snz_pkg::Corners-1:0][3:0]                g_o,
  output logic                                     busy_o
);
  import snz_pkg::*;

  logic [31:0]      gen_q;
  logic [31:0]      gen_d;
  logic [AddrW-1:0] cnt_q;
  logic             busy_q;
  logic [3:0]       gi_d;

  // two copies per level, each read at two addresses
  logic [AddrW-1:0] hash1a_mem [TableDep];
  logic [AddrW-1:0] hash1b_mem [TableDep];
  logic [AddrW-1:0] hash2a_mem [TableDep];
  logic [AddrW-1:0] hash2b_mem [TableDep];
  logic [3:0]       grada_mem  [TableDep];
  logic [3:0]       gradb_mem  [TableDep];

  // next generator output and its gradient index
  assign gen_d = xorshift32(gen_q);
  assign gi_d  = mod12(gen_d[AddrW-1:0]);

  // builder sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= SeedReset;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else if (cfg_we_i) begin
      gen_q  <= cfg_wdata_i;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      gen_q <= gen_d;
      cnt_q <= cnt_q + AddrW'(1);
      if (cnt_q == AddrW'(TableDep - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // table writes during the sweep
  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_we_i) begin
      hash1a_mem[cnt_q] <= gen_d[AddrW-1:0];
      hash1b_mem[cnt_q] <= gen_d[AddrW-1:0];
      hash2a_mem[cnt_q] <= gen_d[AddrW-1:0];
      hash2b_mem[cnt_q] <= gen_d[AddrW-1:0];
      grada_mem[cnt_q]  <= gi_d;
      gradb_mem[cnt_q]  <= gi_d;
    end
  end

  // registered reads, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      h1_o[0] <= hash1a_mem[addr1_i[0]];
      h1_o[1] <= hash1a_mem[addr1_i[1]];
      h1_o[2] <= hash1b_mem[addr1_i[2]];
      h1_o[3] <= hash1b_mem[addr1_i[3]];
      h2_o[0] <= hash2a_mem[addr2_i[0]];
      h2_o[1] <= hash2a_mem[addr2_i[1]];
      h2_o[2] <= hash2b_mem[addr2_i[2]];
      h2_o[3] <= hash2b_mem[addr2_i[3]];
      g_o[0]  <= grada_mem[addr3_i[0]];
      g_o[1]  <= grada_mem[addr3_i[1]];
      g_o[2]  <= gradb_mem[addr3_i[2]];
      g_o[3]  <= gradb_mem[addr3_i[3]];
    end
  end

  assign busy_o = busy_q;

endmodule

/* rtl/core/simplex_noise_3d.sv */
// ----------------------------------------------------------------------------
// simplex_noise_3d: pipelined 3d simplex gradient noise
// One q16.16 point in, one q1.15 noise sample out, fourteen register stages.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point per beat, x in tdata[31:0], y in [63:32],
//   z in [95:64]. m_axis returns one q1.15 sample per beat in tdata[15:0].
//   cfg_we_i with cfg_wdata_i loads a new seed; write it only while idle.
//   Throughput is one point per cycle while s_axis_tready_o is high. A
//   point's sample passes fourteen register stages, counting the input
//   capture, output register last. The depth is set by the chain of two
//   divide-by-three multiplies, three dependent hash reads and the
//   fourth-power falloff multiplies.
//   After reset, and after each seed write, the hash tables are rebuilt
//   one entry per cycle: s_axis_tready_o stays low until all 256 are written.
//   When the receiver holds m_axis_tready_i low with a sample waiting, the
//   whole pipeline freezes and s_axis_tready_o drops; no beat is lost or
//   repeated, and the waiting sample holds still.
// ----------------------------------------------------------------------------
module simplex_noise_3d (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,      // seed
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // x_coord, y_coord, z_coord
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // noise_value
);
  import snz_pkg::*;

  localparam int unsigned Stages = 14;

  logic              en;
  logic              busy;
  logic [Stages-1:0] vld_q;

  // cell numerator: (4a + b + c) >> 16 plus bias
  function automatic logic [21:0] cell_num(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic signed [31:0] c);
    logic signed [34:0] s;
    s = ({{3{a[31]}}, a} <<< 2) + {{3{b[31]}}, b} + {{3{c[31]}}, c};
    s = s >>> 16;
    return s[21:0] + CellBias;
  endfunction

  // offset from the cell origin in units of 1 / (6 * 2^16), mod 2^22
  function automatic logic [21:0] cell_off(input logic [21:0] a, input logic [19:0] c,
                                           input logic [19:0] sum);
    logic [21:0] a6;
    logic [5:0]  c6;
    a6 = (a << 2) + (a << 1);
    c6 = 6'(c << 2) + 6'(c << 1);
    return a6 - {c6, 16'b0} + {sum[5:0], 16'b0};
  endfunction

  // floor quotient by three through the reciprocal
  function automatic logic [19:0] cell_div(input logic [21:0] n);
    logic [46:0] p;
    p = 47'(n) * 47'(RecipCell);
    return 20'(p[45:25]) - CellShift;
  endfunction

  // stall control
  assign en              = !vld_q[Stages-1] || m_axis_tready_i;
  assign s_axis_tready_o = en && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], s_axis_tvalid_i && !busy};
    end
  end

  // stage 1: input capture
  logic signed [31:0] x1_q, y1_q, z1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= s_axis_tdata_i[31:0];
      y1_q <= s_axis_tdata_i[63:32];
      z1_q <= s_axis_tdata_i[95:64];
    end
  end

  // stage 2: skewed cell numerators
  logic [21:0] nx2_q, ny2_q, nz2_q;
  logic [21:0] xl2_q, yl2_q, zl2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx2_q <= cell_num(x1_q, y1_q, z1_q);
      ny2_q <= cell_num(y1_q, x1_q, z1_q);
      nz2_q <= cell_num(z1_q, x1_q, y1_q);
      xl2_q <= x1_q[21:0];
      yl2_q <= y1_q[21:0];
      zl2_q <= z1_q[21:0];
    end
  end

  // stage 3: lattice cell by reciprocal multiply
  logic [19:0] i3_q, j3_q, k3_q;
  logic [21:0] xl3_q, yl3_q, zl3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      i3_q  <= cell_div(nx2_q);
      j3_q  <= cell_div(ny2_q);
      k3_q  <= cell_div(nz2_q);
      xl3_q <= xl2_q;
      yl3_q <= yl2_q;
      zl3_q <= zl2_q;
    end
  end

  // stage 4: exact offsets from the cell origin
  logic [19:0]       ijk3;
  logic signed [21:0] x04_q, y04_q, z04_q;
  logic [AddrW-1:0]  i4_q, j4_q, k4_q;
  assign ijk3 = i3_q + j3_q + k3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x04_q <= cell_off(xl3_q, i3_q, ijk3);
      y04_q <= cell_off(yl3_q, j3_q, ijk3);
      z04_q <= cell_off(zl3_q, k3_q, ijk3);
      i4_q  <= i3_q[AddrW-1:0];
      j4_q  <= j3_q[AddrW-1:0];
      k4_q  <= k3_q[AddrW-1:0];
    end
  end

  // tetrahedron choice
  tetra_t tet4;
  always_comb begin
    tet4 = '0;
    if (x04_q >= y04_q) begin
      priority if (y04_q >= z04_q) tet4 = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
      else if (x04_q >= z04_q)     tet4 = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      else                         tet4 = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    end else begin
      priority if (y04_q < z04_q)  tet4 = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      else if (x04_q < z04_q)      tet4 = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
      else                         tet4 = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    end
  end

  // hash level one addresses
  logic [Corners-1:0][AddrW-1:0] addr1, addr2, addr3;
  logic [Corners-1:0][AddrW-1:0] h1, h2;
  logic [Corners-1:0][3:0]       g;
  assign addr1[0] = k4_q;
  assign addr1[1] = k4_q + AddrW'(tet4.k1);
  assign addr1[2] = k4_q + AddrW'(tet4.k2);
  assign addr1[3] = k4_q + AddrW'(1);

  // stage 5: offset numerators, x0 * 128 + 1 with bias
  logic [28:0]       ax5_q, ay5_q, az5_q;
  logic [29:0]       nx5_q, ny5_q, nz5_q;
  tetra_t            tet5_q;
  logic [AddrW-1:0]  i5_q, j5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax5_q  <= {x04_q, 7'd1};
      ay5_q  <= {y04_q, 7'd1};
      az5_q  <= {z04_q, 7'd1};
      nx5_q  <= {x04_q[21], x04_q, 7'd1} + OffBias;
      ny5_q  <= {y04_q[21], y04_q, 7'd1} + OffBias;
      nz5_q  <= {z04_q[21], z04_q, 7'd1} + OffBias;
      tet5_q <= tet4;
      i5_q   <= i4_q;
      j5_q   <= j4_q;
    end
  end

  assign addr2[0] = j5_q + h1[0];
  assign addr2[1] = j5_q + AddrW'(tet5_q.j1) + h1[1];
  assign addr2[2] = j5_q + AddrW'(tet5_q.j2) + h1[2];
  assign addr2[3] = j5_q + AddrW'(1) + h1[3];

  // stage 6: floor divide by three through the reciprocal
  logic [61:0] px5, py5, pz5;
  logic [28:0] qx6_q, qy6_q, qz6_q;
  logic [28:0] ax6_q, ay6_q, az6_q;
  tetra_t      tet6_q;
  logic [AddrW-1:0] i6_q;
  assign px5 = 62'(nx5_q) * 62'(RecipOff);
  assign py5 = 62'(ny5_q) * 62'(RecipOff);
  assign pz5 = 62'(nz5_q) * 62'(RecipOff);
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx6_q  <= px5[60:32];
      qy6_q  <= py5[60:32];
      qz6_q  <= pz5[60:32];
      ax6_q  <= ax5_q;
      ay6_q  <= ay5_q;
      az6_q  <= az5_q;
      tet6_q <= tet5_q;
      i6_q   <= i5_q;
    end
  end

  assign addr3[0] = i6_q + h2[0];
  assign addr3[1] = i6_q + AddrW'(tet6_q.i1) + h2[1];
  assign addr3[2] = i6_q + AddrW'(tet6_q.i2) + h2[2];
  assign addr3[3] = i6_q + AddrW'(1) + h2[3];

  snz_tables u_tables (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_en_i     (en),
    .addr1_i     (addr1),
    .addr2_i     (addr2),
    .addr3_i     (addr3),
    .h1_o        (h1),
    .h2_o        (h2),
    .g_o         (g),
    .busy_o      (busy)
  );

  // corner coordinates in q24 from one quotient and remainder per axis
  function automatic logic [3*27-1:0] corner_set(input logic [28:0] q, input logic [28:0] a,
                                                 input logic f1, input logic f2);
    logic signed [28:0] q0;
    logic [1:0]         r0;
    logic signed [28:0] c1;
    logic signed [28:0] c2;
    logic signed [28:0] c3;
    q0 = q - OffShift;
    r0 = a[1:0] - 2'(q0[1:0] + (q0[1:0] << 1));
    c1 = q0 + (f1 ? C1Far : C1Near) + 29'(r0 != 2'd0);
    c2 = q0 + (f2 ? C2Far : C2Near) + 29'(r0 == 2'd2);
    c3 = q0 + C3Off;
    return {c3[26:0], c2[26:0], c1[26:0]};
  endfunction

  // stage 7: corner coordinates
  coord_t [Corners-1:0] cx7_q, cy7_q, cz7_q;
  logic [3*27-1:0] sx6, sy6, sz6;
  assign sx6 = corner_set(qx6_q, ax6_q, tet6_q.i1, tet6_q.i2);
  assign sy6 = corner_set(qy6_q, ay6_q, tet6_q.j1, tet6_q.j2);
  assign sz6 = corner_set(qz6_q, az6_q, tet6_q.k1, tet6_q.k2);
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx7_q[0] <= 27'(qx6_q - OffShift);
      cy7_q[0] <= 27'(qy6_q - OffShift);
      cz7_q[0] <= 27'(qz6_q - OffShift);
      for (int c = 1; c < Corners; c++) begin
        cx7_q[c] <= sx6[(c-1)*27 +: 27];
        cy7_q[c] <= sy6[(c-1)*27 +: 27];
        cz7_q[c] <= sz6[(c-1)*27 +: 27];
      end
    end
  end

  // stage 8: squared distances per axis
  logic [Corners-1:0][51:0] sqx8_q, sqy8_q, sqz8_q;
  coord_t [Corners-1:0]     cx8_q, cy8_q, cz8_q;
  logic [Corners-1:0][3:0]  g8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < Corners; c++) begin
        sqx8_q[c] <= 52'($signed(cx7_q[c]) * $signed(cx7_q[c]));
        sqy8_q[c] <= 52'($signed(cy7_q[c]) * $signed(cy7_q[c]));
        sqz8_q[c] <= 52'($signed(cz7_q[c]) * $signed(cz7_q[c]));
      end
      cx8_q <= cx7_q;
      cy8_q <= cy7_q;
      cz8_q <= cz7_q;
      g8_q  <= g;
    end
  end

  // stage 9: radial falloff base and gradient dot
  logic signed [Corners-1:0][53:0] t9_q;
  logic signed [Corners-1:0][27:0] dot9_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < Corners; c++) begin
        t9_q[c]   <= RadiusSq - 54'(sqx8_q[c]) - 54'(sqy8_q[c]) - 54'(sqz8_q[c]);
        dot9_q[c] <= grad_dot(g8_q[c], cx8_q[c], cy8_q[c], cz8_q[c]);
      end
    end
  end

  // stage 10: t rounded to q24, squared
  logic [Corners-1:0][47:0]        tsq10_q;
  logic [Corners-1:0]              neg10_q;
  logic signed [Corners-1:0][27:0] dot10_q;
  logic [Corners-1:0][48:0]        tr9;
  always_comb begin
    for (int c = 0; c < Corners; c++) begin
      tr9[c] = 49'(t9_q[c][47:0]) + HalfQ24;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < Corners; c++) begin
        tsq10_q[c] <= 48'(tr9[c][47:24]) * 48'(tr9[c][47:24]);
        neg10_q[c] <= t9_q[c][53];
      end
      dot10_q <= dot9_q;
    end
  end

  // stage 11: t^2 rounded, squared
  logic [Corners-1:0][47:0]        t4w11_q;
  logic [Corners-1:0]              neg11_q;
  logic signed [Corners-1:0][27:0] dot11_q;
  logic [Corners-1:0][48:0]        tr10;
  always_comb begin
    for (int c = 0; c < Corners; c++) begin
      tr10[c] = 49'(tsq10_q[c]) + HalfQ24;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < Corners; c++) begin
        t4w11_q[c] <= 48'(tr10[c][47:24]) * 48'(tr10[c][47:24]);
      end
      neg11_q <= neg10_q;
      dot11_q <= dot10_q;
    end
  end

  // stage 12: t^4 times the gradient dot, zero where t is negative
  logic signed [Corners-1:0][52:0] prod12_q;
  logic [Corners-1:0][48:0]        tr11;
  logic signed [Corners-1:0][24:0] t4s11;
  always_comb begin
    for (int c = 0; c < Corners; c++) begin
      tr11[c]  = 49'(t4w11_q[c]) + HalfQ24;
      t4s11[c] = {1'b0, tr11[c][47:24]};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < Corners; c++) begin
        prod12_q[c] <= neg11_q[c] ? '0 :
                       53'($signed(t4s11[c]) * $signed(dot11_q[c]));
      end
    end
  end

  // stage 13: pairwise corner sums
  logic signed [53:0] p01_13_q, p23_13_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p01_13_q <= 54'($signed(prod12_q[0])) + 54'($signed(prod12_q[1]));
      p23_13_q <= 54'($signed(prod12_q[2])) + 54'($signed(prod12_q[3]));
    end
  end

  // stage 14: final sum, round half up to q15, saturate
  logic signed [54:0] sum13;
  logic signed [26:0] v13;
  logic [OutW-1:0]    out14_q;
  assign sum13 = 55'(p01_13_q) + 55'(p23_13_q) + 55'sd134217728;
  assign v13   = 27'(sum13 >>> 28);
  always_ff @(posedge clk_i) begin
    if (en) begin
      priority if (v13 > 27'sd32767) out14_q <= 16'h7fff;
      else if (v13 < -27'sd32768)    out14_q <= 16'h8000;
      else                           out14_q <= v13[OutW-1:0];
    end
  end

  assign m_axis_tvalid_o = vld_q[Stages-1];
  assign m_axis_tdata_o  = out14_q;

endmodule

/* rtl/core/snz_checker.sv */
// ----------------------------------------------------------------------------
// snz_checker: port-level checks for simplex_noise_3d
// Watches stall propagation, seed-write behavior and output hold.
// ----------------------------------------------------------------------------
module snz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a held output stalls the input side in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // a seed write starts a table rebuild
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready_o)
    else $error("input ready right after seed write");

  // stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output beat changed under stall");

endmodule

bind simplex_noise_3d snz_checker u_snz_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
